/* rtl/hclbe_pkg.sv */
// Shared types, constants and the header field text for the Content-Length body extractor.
package hclbe_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int MAX_VALUE_LINE_DEFAULT = 256;
   localparam int MATCH_TEXT_BYTES = 15;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [23:0] BLANK_LINE_HEAD = 24'h0D0A0D;

   localparam logic KIND_BODY = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic                   kind;
      logic [7:0]             body_byte;
      logic                   body_last;
      logic [LENGTH_BITS-1:0] parsed_length;
      logic                   length_found;
      logic                   truncated;
   } rsp_type;

   // Characters of "Content-Length:" by position.
   function automatic logic [7:0] field_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0: ch = 8'h43;
         4'd1: ch = 8'h6F;
         4'd2: ch = 8'h6E;
         4'd3: ch = 8'h74;
         4'd4: ch = 8'h65;
         4'd5: ch = 8'h6E;
         4'd6: ch = 8'h74;
         4'd7: ch = 8'h2D;
         4'd8: ch = 8'h4C;
         4'd9: ch = 8'h65;
         4'd10: ch = 8'h6E;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h74;
         4'd13: ch = 8'h68;
         4'd14: ch = 8'h3A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/http_content_length_body_extractor.sv */
// Top level of the Content-Length body extractor: header scan, length parse and body output.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | req_data (req_type)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//
// One message byte is taken per cycle; the parser state updates at the edge that accepts it.
// Each request yields up to two results, which enter a four-entry result queue and leave one
// per cycle while rsp_ready is high; a request with a body byte and a report takes two entries.
// Requests are taken while the queue has room for two results.
// Reset is synchronous and returns the parser to the start of a message with the queue empty.
module http_content_length_body_extractor
   import hclbe_pkg::*;
#(
   parameter int MAX_VALUE_LINE = MAX_VALUE_LINE_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int COUNT_BITS = $clog2(MAX_VALUE_LINE + 2);
   localparam int WIDE_BITS = LENGTH_BITS + 4;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   typedef enum logic [1:0] {
      SCAN_SEARCH,
      SCAN_VALUE,
      SCAN_FOUND,
      SCAN_NONE
   } scan_type;

   typedef enum logic [1:0] {
      NUM_BLANKS,
      NUM_DIGITS,
      NUM_STOPPED
   } num_type;

   logic [3:0]             match_position_ff, match_position_in;
   scan_type               scan_phase_ff, scan_phase_in;
   logic [COUNT_BITS-1:0]  value_char_count_ff, value_char_count_in;
   num_type                number_phase_ff, number_phase_in;
   logic                   negative_sign_ff, negative_sign_in;
   logic [LENGTH_BITS-1:0] length_acc_ff, length_acc_in;
   logic [23:0]            recent_bytes_ff, recent_bytes_in;
   logic                   in_body_ff, in_body_in;
   logic [LENGTH_BITS-1:0] body_remaining_ff, body_remaining_in;

   rsp_type                   rsp_queue_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_BITS:0]     count_ff, count_in;

   logic                   accept;
   logic                   pop;
   logic [7:0]             ch;
   logic                   is_digit;
   logic [WIDE_BITS-1:0]   acc_wide;
   logic [LENGTH_BITS-1:0] acc_next_digit;
   logic [3:0]             match_step;
   logic                   body_out;
   logic                   body_last;
   logic                   found;
   logic                   trunc;
   rsp_type                body_rsp;
   rsp_type                report_rsp;
   logic                   push0;
   logic                   push1;
   rsp_type                push0_data;

   assign accept = req_valid && req_ready;
   assign pop = rsp_valid && rsp_ready;
   assign ch = req_data.data_byte;
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

   assign acc_wide = WIDE_BITS'({length_acc_ff, 3'b000}) + WIDE_BITS'({length_acc_ff, 1'b0})
                     + WIDE_BITS'(ch - CHAR_ZERO);
   assign acc_next_digit = (acc_wide > WIDE_BITS'(LEN_MAX)) ? LEN_MAX
                                                            : acc_wide[LENGTH_BITS-1:0];

   assign match_step = ((match_position_ff != 4'(MATCH_TEXT_BYTES))
                        && (ch == field_char(match_position_ff)))
                       ? match_position_ff + 4'd1
                       : ((ch == field_char(4'd0)) ? 4'd1 : 4'd0);

   always_comb begin
      match_position_in = match_position_ff;
      scan_phase_in = scan_phase_ff;
      value_char_count_in = value_char_count_ff;
      number_phase_in = number_phase_ff;
      negative_sign_in = negative_sign_ff;
      length_acc_in = length_acc_ff;
      recent_bytes_in = recent_bytes_ff;
      in_body_in = in_body_ff;
      body_remaining_in = body_remaining_ff;
      body_out = 1'b0;
      body_last = 1'b0;

      if (in_body_ff) begin
         if (body_remaining_ff != '0) begin
            body_remaining_in = body_remaining_ff - LENGTH_BITS'(1);
            body_out = 1'b1;
            body_last = (body_remaining_ff == LENGTH_BITS'(1));
         end
      end else begin
         unique case (scan_phase_ff)
            SCAN_SEARCH: begin
               if (match_step == 4'(MATCH_TEXT_BYTES)) begin
                  match_position_in = 4'd0;
                  scan_phase_in = SCAN_VALUE;
                  value_char_count_in = '0;
                  number_phase_in = NUM_BLANKS;
                  negative_sign_in = 1'b0;
                  length_acc_in = '0;
               end else begin
                  match_position_in = match_step;
               end
            end
            SCAN_VALUE: begin
               if ((ch == CHAR_LF) || (ch == CHAR_CR)) begin
                  if ((value_char_count_ff > COUNT_BITS'(MAX_VALUE_LINE))
                      || negative_sign_ff || (length_acc_ff == '0)) begin
                     scan_phase_in = SCAN_NONE;
                     length_acc_in = '0;
                  end else begin
                     scan_phase_in = SCAN_FOUND;
                  end
               end else begin
                  if (value_char_count_ff <= COUNT_BITS'(MAX_VALUE_LINE)) begin
                     value_char_count_in = value_char_count_ff + COUNT_BITS'(1);
                  end
                  unique case (number_phase_ff)
                     NUM_BLANKS: begin
                        if ((ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_VT)
                            || (ch == CHAR_FF)) begin
                           number_phase_in = NUM_BLANKS;
                        end else if ((ch == CHAR_PLUS) || (ch == CHAR_MINUS)) begin
                           negative_sign_in = (ch == CHAR_MINUS);
                           number_phase_in = NUM_DIGITS;
                        end else if (is_digit) begin
                           number_phase_in = NUM_DIGITS;
                           length_acc_in = acc_next_digit;
                        end else begin
                           number_phase_in = NUM_STOPPED;
                        end
                     end
                     NUM_DIGITS: begin
                        if (is_digit) begin
                           length_acc_in = acc_next_digit;
                        end else begin
                           number_phase_in = NUM_STOPPED;
                        end
                     end
                     default: begin
                        number_phase_in = number_phase_ff;
                     end
                  endcase
               end
            end
            default: begin
               scan_phase_in = scan_phase_ff;
            end
         endcase
         if ((recent_bytes_ff == BLANK_LINE_HEAD) && (ch == CHAR_LF)) begin
            in_body_in = 1'b1;
            body_remaining_in = (scan_phase_in == SCAN_FOUND) ? length_acc_in : '0;
         end
         recent_bytes_in = {recent_bytes_ff[15:0], ch};
      end

      found = (scan_phase_in == SCAN_FOUND);
      trunc = found && (!in_body_in || (body_remaining_in != '0));

      body_rsp = '0;
      body_rsp.kind = KIND_BODY;
      body_rsp.body_byte = ch;
      body_rsp.body_last = body_last;

      report_rsp = '0;
      report_rsp.kind = KIND_REPORT;
      report_rsp.parsed_length = found ? length_acc_in : '0;
      report_rsp.length_found = found;
      report_rsp.truncated = trunc;

      if (req_data.message_end) begin
         match_position_in = 4'd0;
         scan_phase_in = SCAN_SEARCH;
         value_char_count_in = '0;
         number_phase_in = NUM_BLANKS;
         negative_sign_in = 1'b0;
         length_acc_in = '0;
         recent_bytes_in = '0;
         in_body_in = 1'b0;
         body_remaining_in = '0;
      end
   end

   assign push0 = accept && (body_out || req_data.message_end);
   assign push1 = accept && body_out && req_data.message_end;
   assign push0_data = body_out ? body_rsp : report_rsp;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push0) + RSP_PTR_BITS'(push1);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_BITS'(pop);
      count_in = count_ff + (RSP_PTR_BITS + 1)'(push0) + (RSP_PTR_BITS + 1)'(push1)
                 - (RSP_PTR_BITS + 1)'(pop);
   end

   assign req_ready = (count_ff <= (RSP_PTR_BITS + 1)'(RSP_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data = rsp_queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         match_position_ff <= 4'd0;
         scan_phase_ff <= SCAN_SEARCH;
         value_char_count_ff <= '0;
         number_phase_ff <= NUM_BLANKS;
         negative_sign_ff <= 1'b0;
         length_acc_ff <= '0;
         recent_bytes_ff <= '0;
         in_body_ff <= 1'b0;
         body_remaining_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            match_position_ff <= match_position_in;
            scan_phase_ff <= scan_phase_in;
            value_char_count_ff <= value_char_count_in;
            number_phase_ff <= number_phase_in;
            negative_sign_ff <= negative_sign_in;
            length_acc_ff <= length_acc_in;
            recent_bytes_ff <= recent_bytes_in;
            in_body_ff <= in_body_in;
            body_remaining_ff <= body_remaining_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push0) begin
         rsp_queue_ff[wr_ptr_ff] <= push0_data;
      end
      if (push1) begin
         rsp_queue_ff[wr_ptr_ff + RSP_PTR_BITS'(1)] <= report_rsp;
      end
   end

   // The result queue never holds more entries than it has.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (RSP_PTR_BITS + 1)'(RSP_DEPTH))
      else $error("result queue overflow");

   // A request that ends the message leaves the parser at the start of a new message.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_data.message_end |=>
         (scan_phase_ff == SCAN_SEARCH) && !in_body_ff && (body_remaining_ff == '0))
      else $error("parser not cleared after message end");

   // Body bytes are only counted down once the blank line has been seen.
   assert property (@(posedge clock) disable iff (reset)
      (body_remaining_ff != '0) |-> in_body_ff)
      else $error("body count outside the body");

   // The value line always closes before the blank line can start the body.
   assert property (@(posedge clock) disable iff (reset)
      (scan_phase_ff == SCAN_VALUE) |-> !in_body_ff)
      else $error("value line open inside the body");

   // The field matcher never rests on a completed match.
   assert property (@(posedge clock) disable iff (reset)
      match_position_ff < 4'(MATCH_TEXT_BYTES))
      else $error("field match position out of range");

endmodule
